[design/gwwb_pkg.sv]
// Shared widths, command codes and lane handshake types for the gray-world balance block.
// No dependencies.
package gwwb_pkg;

    localparam int unsigned SumW       = 28;
    localparam int unsigned CountW     = 21;
    localparam int unsigned PixW       = 8;
    localparam int unsigned StepW      = 5;
    localparam int unsigned MAX_PIXELS = 1048576;
    localparam int unsigned GrayShift  = 7;
    localparam logic [PixW-1:0] SatMax = 8'd255;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_ACCUM   = 2'd1;
    localparam logic [1:0] CMD_BALANCE = 2'd2;

    typedef enum logic [1:0] {
        LANE_IDLE,
        LANE_AVG,
        LANE_SCALE,
        LANE_DONE
    } lane_state_t;

    typedef enum logic {
        TOP_IDLE,
        TOP_BUSY
    } top_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } lane_ctrl_t;

    typedef struct packed {
        logic done;
        logic zero;
    } lane_stat_t;

endpackage

[design/gwwb_lane.sv]
// One colour channel lane: average by restoring division, then scaling division.
// Depends on gwwb_pkg.
module gwwb_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gwwb_pkg::lane_ctrl_t         ctrl,
    input  logic [gwwb_pkg::PixW-1:0]    value,
    input  logic [gwwb_pkg::SumW-1:0]    sum,
    input  logic [gwwb_pkg::CountW-1:0]  count,
    output gwwb_pkg::lane_stat_t         stat,
    output logic [gwwb_pkg::PixW-1:0]    result
);
    import gwwb_pkg::*;

    lane_state_t       state_reg, state_next;
    logic [SumW-1:0]   rem_reg, rem_next;
    logic [SumW-1:0]   quo_reg, quo_next;
    logic [SumW-1:0]   div_reg, div_next;
    logic [StepW-1:0]  step_reg, step_next;
    logic [PixW-1:0]   value_reg, value_next;
    logic [PixW-1:0]   result_reg, result_next;
    logic              zero_reg, zero_next;

    logic [SumW:0]     trial;
    logic [SumW:0]     diff;
    logic              fits;
    logic [SumW-1:0]   rem_step;
    logic [SumW-1:0]   quo_step;

    // one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SumW-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = (trial >= {1'b0, div_reg});
        rem_step = fits ? diff[SumW-1:0] : trial[SumW-1:0];
        quo_step = {quo_reg[SumW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LANE_IDLE;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        div_reg    <= div_next;
        step_reg   <= step_next;
        value_reg  <= value_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        div_next    = div_reg;
        step_next   = step_reg;
        value_next  = value_reg;
        result_next = result_reg;
        zero_next   = zero_reg;
        unique case (state_reg)
            LANE_IDLE:
            begin
                if (ctrl.start)
                begin
                    value_next = value;
                    zero_next  = 1'b0;
                    if (count == '0)
                    begin
                        // empty frame: average taken as zero
                        zero_next   = 1'b1;
                        result_next = SatMax;
                        state_next  = LANE_DONE;
                    end
                    else
                    begin
                        rem_next   = '0;
                        quo_next   = sum;
                        div_next   = {{(SumW-CountW){1'b0}}, count};
                        step_next  = StepW'(SumW - 1);
                        state_next = LANE_AVG;
                    end
                end
            end
            LANE_AVG:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    if (quo_step == '0)
                    begin
                        zero_next   = 1'b1;
                        result_next = SatMax;
                        state_next  = LANE_DONE;
                    end
                    else
                    begin
                        rem_next   = '0;
                        quo_next   = {{(SumW-PixW-GrayShift){1'b0}}, value_reg,
                                      {GrayShift{1'b0}}};
                        div_next   = quo_step;
                        step_next  = StepW'(SumW - 1);
                        state_next = LANE_SCALE;
                    end
                end
            end
            LANE_SCALE:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    // saturate
                    result_next = (quo_step > {{(SumW-PixW){1'b0}}, SatMax}) ?
                                  SatMax : quo_step[PixW-1:0];
                    state_next  = LANE_DONE;
                end
            end
            LANE_DONE:
            begin
                if (ctrl.ack)
                begin
                    state_next = LANE_IDLE;
                end
            end
            default:
            begin
                state_next = LANE_IDLE;
            end
        endcase
    end

    assign stat.done = (state_reg == LANE_DONE);
    assign stat.zero = zero_reg;
    assign result    = result_reg;

endmodule

[design/gray_world_white_balance_top.sv]
// Gray-world white balance: clear and accumulate transfers update the sums and count.
// A balance transfer occupies the block for two 28-step restoring divisions per channel
// lane, plus load and output, then one result is registered. Throughput: one clear or
// accumulate per cycle while idle; no transfer is taken until the balance result loads.
// Reset (rst_n, asynchronous, active low) zeroes sums, count and all valid state.
// Depends on gwwb_pkg and gwwb_lane.
module gray_world_white_balance_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] blue_in,
    input  logic [7:0] green_in,
    input  logic [7:0] red_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] blue_out,
    output logic [7:0] green_out,
    output logic [7:0] red_out,
    output logic       avg_zero
);
    import gwwb_pkg::*;

    top_state_t        state_reg, state_next;
    logic [SumW-1:0]   blue_sum_reg, green_sum_reg, red_sum_reg;
    logic [CountW-1:0] count_reg;
    logic              out_valid_reg;
    logic [PixW-1:0]   blue_out_reg, green_out_reg, red_out_reg;
    logic              avg_zero_reg;

    lane_ctrl_t        ctrl;
    lane_stat_t        blue_stat, green_stat, red_stat;
    logic [PixW-1:0]   blue_res, green_res, red_res;
    logic              accept;
    logic              all_done;
    logic              load_out;
    logic              room;

    // Take a transfer only while no balance is in flight.
    assign in_stall = (state_reg != TOP_IDLE);
    assign accept   = in_valid && !in_stall;
    assign all_done = blue_stat.done && green_stat.done && red_stat.done;
    // The output register frees up in the same cycle its result is taken.
    assign room     = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == TOP_BUSY) && all_done && room;

    assign ctrl.start = accept && (cmd == CMD_BALANCE);
    assign ctrl.ack   = load_out;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TOP_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = TOP_BUSY;
                end
            end
            TOP_BUSY:
            begin
                if (load_out)
                begin
                    state_next = TOP_IDLE;
                end
            end
            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TOP_IDLE;
            blue_sum_reg  <= '0;
            green_sum_reg <= '0;
            red_sum_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (cmd == CMD_CLEAR))
            begin
                blue_sum_reg  <= '0;
                green_sum_reg <= '0;
                red_sum_reg   <= '0;
                count_reg     <= '0;
            end
            else if (accept && (cmd == CMD_ACCUM) && (count_reg < CountW'(MAX_PIXELS)))
            begin
                // drop pixels past the limit so no sum can overflow
                blue_sum_reg  <= blue_sum_reg  + {{(SumW-PixW){1'b0}}, blue_in};
                green_sum_reg <= green_sum_reg + {{(SumW-PixW){1'b0}}, green_in};
                red_sum_reg   <= red_sum_reg   + {{(SumW-PixW){1'b0}}, red_in};
                count_reg     <= count_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Merge: gather the lane results and the shared zero-average flag.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            blue_out_reg  <= blue_res;
            green_out_reg <= green_res;
            red_out_reg   <= red_res;
            avg_zero_reg  <= blue_stat.zero || green_stat.zero || red_stat.zero;
        end
    end

    gwwb_lane u_blue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .value  (blue_in),
        .sum    (blue_sum_reg),
        .count  (count_reg),
        .stat   (blue_stat),
        .result (blue_res)
    );

    gwwb_lane u_green (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .value  (green_in),
        .sum    (green_sum_reg),
        .count  (count_reg),
        .stat   (green_stat),
        .result (green_res)
    );

    gwwb_lane u_red (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .value  (red_in),
        .sum    (red_sum_reg),
        .count  (count_reg),
        .stat   (red_stat),
        .result (red_res)
    );

    assign out_valid = out_valid_reg;
    assign blue_out  = blue_out_reg;
    assign green_out = green_out_reg;
    assign red_out   = red_out_reg;
    assign avg_zero  = avg_zero_reg;

endmodule
